>>> rtl/core/dfsbe_pkg.sv
// Shared types and constants of the depth-first search back-edge finder.
package dfsbe_pkg;

  localparam int NODES = 16;
  localparam int NODE_W = 4;
  localparam int COUNT_W = 5;

  localparam logic [2:0] OP_ADD_EDGE = 3'd0;
  localparam logic [2:0] OP_SEARCH   = 3'd1;
  localparam logic [2:0] OP_READ_NODE = 3'd2;
  localparam logic [2:0] OP_READ_ROW = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  typedef struct packed {
    logic latch_item;
    logic exec_simple;
    logic search_init;
    logic load_top;
    logic scan;
    logic check;
    logic load_out;
  } dfsbe_cmd_t;

  typedef struct packed {
    logic op_search;
    logic bad;
    logic found;
    logic is_parent;
    logic last;
    logic visited_v;
  } dfsbe_stat_t;

endpackage

>>> rtl/core/dfs_back_edge_finder.sv
// Top level of the depth-first search back-edge finder.
//
// The block keeps an undirected graph of up to sixteen nodes as an adjacency
// bit matrix and answers every input beat with exactly one result beat. Adding
// an edge, clearing, and reading a node or a back-edge row pass through an
// execute state and a done state, where the result register is loaded; the
// next input beat is taken once the block is back in idle. A search walks the
// graph with an explicit stack: the node on top is loaded in a top state and
// its row scanned in the scan state that follows, every neighbour found costs
// a scan step, and every neighbour other than the parent a check step. A
// single scan unit finds the next neighbour of the node on top of the stack.
// One item is processed at a time; the result register holds the finished beat
// while downstream stalls. The node_count register is written through its own
// channel, which is ready whenever the block is idle; values above sixteen act
// as sixteen.
module dfs_back_edge_finder
  import dfsbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic [3:0]         node_a,
  input  logic [3:0]         node_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic               node_visited,
  output logic signed [4:0]  node_parent,
  output logic signed [4:0]  node_discovery,
  output logic [4:0]         visited_total,
  output logic [6:0]         back_edge_total,
  output logic [15:0]        back_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  dfsbe_cmd_t  cmd;
  dfsbe_stat_t stat;

  dfsbe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cfg_ready(cfg_ready),
    .stat(stat), .cmd(cmd)
  );

  dfsbe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .opcode(opcode), .node_a(node_a), .node_b(node_b),
    .status(status), .node_visited(node_visited), .node_parent(node_parent),
    .node_discovery(node_discovery), .visited_total(visited_total),
    .back_edge_total(back_edge_total), .back_row(back_row)
  );

endmodule

>>> rtl/core/dfsbe_ctrl.sv
// Sequencing state machine of the back-edge finder.
module dfsbe_ctrl
  import dfsbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cfg_ready,
  input  dfsbe_stat_t stat,
  output dfsbe_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_TOP, S_SCAN, S_CHECK, S_DONE} state_t;
  state_t state;

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.latch_item = in_valid;
      S_EXEC: begin
        if (stat.op_search && !stat.bad) cmd.search_init = 1'b1;
        else cmd.exec_simple = 1'b1;
      end
      S_TOP:   cmd.load_top = 1'b1;
      S_SCAN:  cmd.scan = 1'b1;
      S_CHECK: cmd.check = 1'b1;
      S_DONE:  cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          if (stat.op_search && !stat.bad) state <= S_TOP;
          else state <= S_DONE;
        end
        S_TOP: state <= S_SCAN;
        S_SCAN: begin
          if (!stat.found) state <= stat.last ? S_DONE : S_TOP;
          else if (!stat.is_parent) state <= S_CHECK;
        end
        S_CHECK: state <= stat.visited_v ? S_SCAN : S_TOP;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/dfsbe_datapath.sv
// Graph storage, search registers and result register of the back-edge finder.
module dfsbe_datapath
  import dfsbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dfsbe_cmd_t         cmd,
  output dfsbe_stat_t        stat,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic [2:0]         opcode,
  input  logic [3:0]         node_a,
  input  logic [3:0]         node_b,
  output logic               status,
  output logic               node_visited,
  output logic signed [4:0]  node_parent,
  output logic signed [4:0]  node_discovery,
  output logic [4:0]         visited_total,
  output logic [6:0]         back_edge_total,
  output logic [15:0]        back_row
);

  logic [4:0]          node_count;
  logic [2:0]          op_r;
  logic [NODE_W-1:0]   a_r, b_r;
  logic [NODES-1:0]    adj [NODES];
  logic [NODES-1:0]    back [NODES];
  logic [NODES-1:0]    visited;
  logic signed [4:0]   parent [NODES];
  logic [NODE_W-1:0]   disc [NODES];
  logic [NODE_W-1:0]   stack [NODES];
  logic [4:0]          scanpos [NODES];
  logic [4:0]          sp, cnt;
  logic [6:0]          bcnt;
  logic [NODE_W-1:0]   u_r, v_r;
  logic [4:0]          scan_r;
  logic signed [4:0]   par_r;
  logic [NODE_W-1:0]   disc_u_r;

  logic [4:0]          lim, sp_dec;
  logic                bad_a, bad_b, bad;
  logic [NODE_W-1:0]   top_node, rd_addr, v_found;
  logic [NODES-1:0]    cand;
  logic                found;

  logic                status_next, node_visited_next;
  logic signed [4:0]   node_parent_next, node_discovery_next;
  logic [4:0]          visited_total_next;
  logic [6:0]          back_edge_total_next;
  logic [15:0]         back_row_next;

  assign lim = (node_count > 5'(NODES)) ? 5'(NODES) : node_count;
  assign bad_a = {1'b0, a_r} >= lim;
  assign bad_b = {1'b0, b_r} >= lim;
  assign bad = (op_r == OP_ADD_EDGE) ? (bad_a || bad_b) : bad_a;
  assign sp_dec = sp - 5'd1;
  assign top_node = stack[sp_dec[NODE_W-1:0]];
  assign rd_addr = cmd.check ? v_r : (cmd.load_top ? top_node : a_r);

  always_comb begin
    found = 1'b0;
    v_found = '0;
    for (int i = 0; i < NODES; i++) begin
      cand[i] = adj[u_r][i] && (5'(i) >= scan_r) && (5'(i) < lim);
    end
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        v_found = NODE_W'(i);
      end
    end
  end

  always_comb begin
    stat.op_search = (op_r == OP_SEARCH);
    stat.bad = bad;
    stat.found = found;
    stat.is_parent = (par_r == $signed({1'b0, v_found}));
    stat.last = (sp == 5'd1);
    stat.visited_v = visited[v_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      visited <= '0;
      cnt <= '0;
      bcnt <= '0;
      sp <= '0;
      for (int i = 0; i < NODES; i++) begin
        adj[i] <= '0;
        back[i] <= '0;
      end
    end else begin
      if (cfg_we) node_count <= cfg_data;
      if (cmd.latch_item) begin
        op_r <= opcode;
        a_r <= node_a;
        b_r <= node_b;
      end
      if (cmd.exec_simple) begin
        if (op_r == OP_ADD_EDGE && !bad) begin
          adj[a_r][b_r] <= 1'b1;
          adj[b_r][a_r] <= 1'b1;
        end
        if (op_r == OP_CLEAR || op_r == OP_SEARCH) begin
          visited <= '0;
          cnt <= '0;
          bcnt <= '0;
          for (int i = 0; i < NODES; i++) back[i] <= '0;
        end
        if (op_r == OP_CLEAR) begin
          node_count <= '0;
          for (int i = 0; i < NODES; i++) adj[i] <= '0;
        end
      end
      if (cmd.search_init) begin
        visited <= NODES'(1) << a_r;
        for (int i = 0; i < NODES; i++) back[i] <= '0;
        parent[a_r] <= -5'sd1;
        disc[a_r] <= '0;
        scanpos[a_r] <= '0;
        stack[0] <= a_r;
        sp <= 5'd1;
        cnt <= 5'd1;
        bcnt <= '0;
      end
      if (cmd.load_top) begin
        u_r <= top_node;
        scan_r <= scanpos[top_node];
        par_r <= parent[rd_addr];
        disc_u_r <= disc[rd_addr];
      end
      if (cmd.scan) begin
        if (found) begin
          scanpos[u_r] <= {1'b0, v_found} + 5'd1;
          scan_r <= {1'b0, v_found} + 5'd1;
          v_r <= v_found;
        end else begin
          sp <= sp_dec;
        end
      end
      if (cmd.check) begin
        if (visited[v_r]) begin
          if (disc_u_r > disc[rd_addr]) begin
            back[v_r][u_r] <= 1'b1;
            bcnt <= bcnt + 7'd1;
          end
        end else begin
          visited[v_r] <= 1'b1;
          parent[v_r] <= $signed({1'b0, u_r});
          disc[v_r] <= cnt[NODE_W-1:0];
          cnt <= cnt + 5'd1;
          scanpos[v_r] <= '0;
          stack[sp[NODE_W-1:0]] <= v_r;
          sp <= sp + 5'd1;
        end
      end
    end
  end

  // Result fields of the finished item; fields that do not belong to the opcode stay zero.
  always_comb begin
    status_next = 1'b0;
    node_visited_next = 1'b0;
    node_parent_next = '0;
    node_discovery_next = '0;
    visited_total_next = '0;
    back_edge_total_next = '0;
    back_row_next = '0;
    unique case (op_r)
      OP_ADD_EDGE: status_next = bad;
      OP_SEARCH: begin
        status_next = bad;
        visited_total_next = cnt;
        back_edge_total_next = bcnt;
      end
      OP_READ_NODE: begin
        if (bad) status_next = 1'b1;
        else begin
          node_visited_next = visited[a_r];
          node_parent_next = visited[a_r] ? parent[rd_addr] : -5'sd1;
          node_discovery_next = visited[a_r] ? $signed({1'b0, disc[rd_addr]}) : -5'sd1;
        end
      end
      OP_READ_ROW: begin
        if (bad) status_next = 1'b1;
        else back_row_next = back[a_r];
      end
      default: status_next = 1'b0;
    endcase
  end

  // Result register, loaded as the item completes.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= status_next;
      node_visited <= node_visited_next;
      node_parent <= node_parent_next;
      node_discovery <= node_discovery_next;
      visited_total <= visited_total_next;
      back_edge_total <= back_edge_total_next;
      back_row <= back_row_next;
    end
  end

endmodule

>>> rtl/core/dfsbe_checker.sv
// Port-level checks of the back-edge finder and their binding.
module dfsbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic        node_visited,
  input logic [4:0]  visited_total,
  input logic [6:0]  back_edge_total,
  input logic [15:0] back_row
);

  // Only one item is in flight: after an accepted beat the input stalls.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(back_row))
    else $error("stalled result changed");

  a_visited_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && node_visited |-> !status && back_row == 16'd0)
    else $error("node read carries an error or row data");

  a_row_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && back_row != 16'd0 |-> visited_total == 5'd0 && back_edge_total == 7'd0)
    else $error("row read carries search totals");

endmodule

bind dfs_back_edge_finder dfsbe_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .node_visited(node_visited), .visited_total(visited_total),
  .back_edge_total(back_edge_total), .back_row(back_row)
);

>>> tb/sv/tb_dfs_back_edge_finder.sv
// Self-checking testbench of the depth-first search back-edge finder.
module tb_dfs_back_edge_finder
  import dfsbe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One input beat as the driver presents it.
  typedef struct packed {
    logic [2:0] op;
    logic [3:0] a;
    logic [3:0] b;
  } graph_cmd_t;

  // One result beat, every field at the width of its port.
  typedef struct packed {
    logic              status;
    logic              visited;
    logic signed [4:0] parent;
    logic signed [4:0] disc;
    logic [4:0]        reached;
    logic [6:0]        backs;
    logic [15:0]       row;
  } graph_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic [3:0] node_a = '0;
  logic [3:0] node_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status, node_visited;
  logic signed [4:0] node_parent, node_discovery;
  logic [4:0] visited_total;
  logic [6:0] back_edge_total;
  logic [15:0] back_row;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  dfs_back_edge_finder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .node_a(node_a), .node_b(node_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .node_visited(node_visited), .node_parent(node_parent),
    .node_discovery(node_discovery), .visited_total(visited_total),
    .back_edge_total(back_edge_total), .back_row(back_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: a private copy of the graph and of the last search.
  logic [4:0]        pm_count;
  logic [15:0]       pm_adj [NODES];
  logic [15:0]       pm_seen;
  logic signed [4:0] pm_parent [NODES];
  logic signed [4:0] pm_disc [NODES];
  logic [15:0]       pm_backs [NODES];
  int                pm_order;

  graph_cmd_t cmd_queue[$];
  graph_res_t expected_results[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet_tail = 1'b0;
  bit  timed_out = 1'b0;

  function automatic void wipe_search();
    pm_seen = '0;
    pm_order = 0;
    for (int i = 0; i < NODES; i++) begin
      pm_parent[i] = -5'sd1;
      pm_disc[i] = -5'sd1;
      pm_backs[i] = '0;
    end
  endfunction

  // Iterative depth-first walk, neighbours in ascending order.
  function automatic void walk_graph(int start, int lim);
    int stk [NODES];
    int pos [NODES];
    int sp, u, v;
    wipe_search();
    sp = 0;
    pm_seen[start] = 1'b1;
    pm_disc[start] = pm_order[4:0];
    pm_order++;
    stk[sp] = start;
    sp++;
    pos[start] = 0;
    while (sp > 0) begin
      u = stk[sp-1];
      v = pos[u];
      while (v < lim && !pm_adj[u][v]) v++;
      if (v >= lim) begin
        sp--;
        continue;
      end
      pos[u] = v + 1;
      if (v == pm_parent[u]) continue;
      if (pm_seen[v]) begin
        if (pm_disc[u] > pm_disc[v]) pm_backs[v][u] = 1'b1;
      end else if (sp < NODES) begin
        pm_seen[v] = 1'b1;
        pm_parent[v] = u[4:0];
        pm_disc[v] = pm_order[4:0];
        pm_order++;
        pos[v] = 0;
        stk[sp] = v;
        sp++;
      end
    end
  endfunction

  // Applies one command to the predictor and returns the beat it should give.
  function automatic graph_res_t predict_answer(graph_cmd_t c);
    graph_res_t r;
    int lim, total;
    r = '0;
    lim = (pm_count > NODES) ? NODES : pm_count;
    case (c.op)
      OP_ADD_EDGE: begin
        if (c.a >= lim || c.b >= lim) r.status = 1'b1;
        else begin
          pm_adj[c.a][c.b] = 1'b1;
          pm_adj[c.b][c.a] = 1'b1;
        end
      end
      OP_SEARCH: begin
        if (c.a >= lim) begin
          wipe_search();
          r.status = 1'b1;
        end else begin
          walk_graph(c.a, lim);
          total = 0;
          for (int i = 0; i < NODES; i++) total += $countones(pm_backs[i]);
          r.reached = pm_order[4:0];
          r.backs = total[6:0];
        end
      end
      OP_READ_NODE: begin
        if (c.a >= lim) r.status = 1'b1;
        else begin
          r.visited = pm_seen[c.a];
          r.parent = pm_parent[c.a];
          r.disc = pm_disc[c.a];
        end
      end
      OP_READ_ROW: begin
        if (c.a >= lim) r.status = 1'b1;
        else r.row = pm_backs[c.a];
      end
      OP_CLEAR: begin
        for (int i = 0; i < NODES; i++) pm_adj[i] = '0;
        wipe_search();
        pm_count = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: presents queued commands, holds a stalled beat, idles in bursts.
  int drv_gap = 0;
  always @(posedge clk) begin
    graph_cmd_t taken;
    graph_res_t pred;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        taken = cmd_queue.pop_front();
        pred = predict_answer(taken);
        expected_results = {expected_results, pred};
      end
      if (in_valid && in_stall) begin
        // The beat is stalled and stays as it is.
      end else if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        drv_gap <= $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        // The accepted command has left the queue, so the head is the next one.
        in_valid <= 1'b1;
        opcode <= cmd_queue[0].op;
        node_a <= cmd_queue[0].a;
        node_b <= cmd_queue[0].b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: receiver stalls in bursts and each beat is checked field by field.
  int mon_gap = 0;
  always @(posedge clk) begin
    graph_res_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{status, node_visited, node_parent, node_discovery,
                visited_total, back_edge_total, back_row};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        mon_gap <= $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Waits until every queued command has gone in and every result has come.
  task automatic drain_all();
    while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes node_count while the block is idle.
  task automatic set_node_count(logic [4:0] n);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pm_count = n;
  endtask

  function automatic void queue_cmd(logic [2:0] op, logic [3:0] a, logic [3:0] b);
    graph_cmd_t c;
    c = '{op, a, b};
    cmd_queue = {cmd_queue, c};
  endfunction

  // A random graph session: edges, one search, then reads of its results, mixed with invalid opcodes.
  task automatic random_session(int lim);
    int edges;
    edges = $urandom_range(0, 30);
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(0, 9) == 0) queue_cmd(OP_ADD_EDGE, 4'($urandom), 4'($urandom));
      else queue_cmd(OP_ADD_EDGE, 4'($urandom_range(0, lim - 1)),
                     4'($urandom_range(0, lim - 1)));
    end
    queue_cmd(OP_SEARCH, ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                                      : 4'($urandom_range(0, lim - 1)), '0);
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 9))
        0: queue_cmd(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom));
        1: queue_cmd(OP_READ_ROW, 4'($urandom), 4'($urandom));
        2, 3, 4: queue_cmd(OP_READ_NODE, 4'($urandom_range(0, lim - 1)), 4'($urandom));
        default: queue_cmd(OP_READ_ROW, 4'($urandom_range(0, lim - 1)), 4'($urandom));
      endcase
    end
  endtask

  initial begin
    int sent, lim;
    pm_count = '0;
    for (int i = 0; i < NODES; i++) pm_adj[i] = '0;
    wipe_search();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a triangle plus a tail, a self loop, bad indices and opcodes.
    set_node_count(5'd4);
    queue_cmd(OP_ADD_EDGE, 4'd0, 4'd1);
    queue_cmd(OP_ADD_EDGE, 4'd1, 4'd2);
    queue_cmd(OP_ADD_EDGE, 4'd2, 4'd0);
    queue_cmd(OP_ADD_EDGE, 4'd3, 4'd3);
    queue_cmd(OP_ADD_EDGE, 4'd2, 4'd3);
    queue_cmd(OP_ADD_EDGE, 4'd15, 4'd0);
    queue_cmd(OP_ADD_EDGE, 4'd0, 4'd4);
    queue_cmd(OP_SEARCH, 4'd0, 4'd15);
    queue_cmd(OP_READ_NODE, 4'd2, 4'd0);
    queue_cmd(OP_READ_NODE, 4'd0, 4'd0);
    queue_cmd(OP_READ_ROW, 4'd0, 4'd0);
    queue_cmd(OP_READ_ROW, 4'd15, 4'd0);
    queue_cmd(OP_READ_NODE, 4'd9, 4'd0);
    queue_cmd(3'd7, 4'd1, 4'd1);
    queue_cmd(3'd5, 4'd0, 4'd0);
    queue_cmd(OP_SEARCH, 4'd8, 4'd0);
    queue_cmd(OP_READ_NODE, 4'd1, 4'd0);
    drain_all();

    // Lowering the count leaves stale edges that the search must skip.
    set_node_count(5'd2);
    queue_cmd(OP_SEARCH, 4'd1, 4'd0);
    queue_cmd(OP_READ_NODE, 4'd1, 4'd0);
    drain_all();

    // A count above sixteen acts as sixteen; a full ring of nodes.
    set_node_count(5'd31);
    for (int i = 0; i < 16; i++) queue_cmd(OP_ADD_EDGE, 4'(i), 4'((i + 1) % 16));
    queue_cmd(OP_SEARCH, 4'd15, 4'd0);
    queue_cmd(OP_READ_ROW, 4'd15, 4'd0);
    queue_cmd(OP_CLEAR, 4'd0, 4'd0);
    queue_cmd(OP_READ_NODE, 4'd0, 4'd0);
    drain_all();
    set_node_count(5'd0);
    queue_cmd(OP_SEARCH, 4'd0, 4'd0);
    drain_all();

    // Random sessions under varying counts, the sender pausing between them.
    sent = 0;
    while (sent < 1200) begin
      // Clear zeroes the count, so it goes in before the count is written.
      if ($urandom_range(0, 1)) begin
        queue_cmd(OP_CLEAR, 4'($urandom), 4'($urandom));
        sent += 1;
        drain_all();
      end
      case ($urandom_range(0, 5))
        0: lim = 16;
        1: lim = $urandom_range(1, 3);
        default: lim = $urandom_range(2, 16);
      endcase
      set_node_count(($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31)) : 5'(lim));
      if (pm_count > 16) lim = 16;
      for (int s = 0; s < 3; s++) random_session(lim);
      sent += cmd_queue.size();
      if (sent >= 1000) quiet_tail = 1'b1;
      drain_all();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
